[rtl/lpi_pkg.sv]
package lpi_pkg;

  // Coordinate and result formats
  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 64;

  // Exact integer widths along the datapath
  localparam int DIFF_W  = COORD_WIDTH + 1;           // point differences
  localparam int PROD_W  = 2 * DIFF_W;                // one cross product term
  localparam int SUM_W   = PROD_W + 1;                // determinant and numerators
  localparam int NUM_W   = DIFF_W + SUM_W + 1;        // base * den + step * num
  localparam int SHIFT_W = NUM_W + FRAC_BITS;         // scaled dividend magnitude

  // Pipelined divider: quotient bits resolved per stage
  localparam int DIV_BPS    = 3;
  localparam int DIV_STAGES = (SHIFT_W + DIV_BPS - 1) / DIV_BPS;
  localparam int QUOT_W     = DIV_STAGES * DIV_BPS;
  localparam int RND_W      = QUOT_W + 1;
  localparam int CMP_W      = (RND_W > OUT_W + 1) ? RND_W : OUT_W + 1;

  // Stream payload widths
  localparam int IN_DATA_W  = ((8 * COORD_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 2 * OUT_W;
  localparam int OUT_USER_W = 3;

  // Clamp values of the fixed-point result
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_RAY     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ONE  = 2'd1,
    ST_MANY = 2'd2
  } status_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  // Ordered pair with determinant and crossing numerators
  typedef struct packed {
    kind_e              ka;
    kind_e              kb;
    logic               degen;
    logic               use_x;
    coord_t [3:0]       xs;
    coord_t [3:0]       ys;
    diff_t              dx1;
    diff_t              dy1;
    sum_t               den;
    sum_t               tn;
    sum_t               un;
  } geom_t;

  // Dividend magnitudes and divisor for both coordinates
  typedef struct packed {
    status_e                  status;
    logic [1:0]               neg;
    logic [1:0][SHIFT_W-1:0]  mag;
    logic [SUM_W-1:0]         dvs;
  } divin_t;

endpackage

[rtl/lpi_geom.sv]
module lpi_geom (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpi_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [lpi_pkg::IN_USER_W-1:0] in_user_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lpi_pkg::geom_t                out_geom_o
);

  typedef struct packed {
    lpi_pkg::kind_e         ka;
    lpi_pkg::kind_e         kb;
    lpi_pkg::coord_t [3:0]  xs;
    lpi_pkg::coord_t [3:0]  ys;
    lpi_pkg::diff_t         dx1;
    lpi_pkg::diff_t         dy1;
    lpi_pkg::diff_t         dx2;
    lpi_pkg::diff_t         dy2;
    lpi_pkg::diff_t         ex;
    lpi_pkg::diff_t         ey;
  } ga_t;

  typedef struct packed {
    lpi_pkg::kind_e         ka;
    lpi_pkg::kind_e         kb;
    lpi_pkg::coord_t [3:0]  xs;
    lpi_pkg::coord_t [3:0]  ys;
    lpi_pkg::diff_t         dx1;
    lpi_pkg::diff_t         dy1;
    logic                   degen;
    logic                   use_x;
    lpi_pkg::prod_t         pa;
    lpi_pkg::prod_t         pb;
    lpi_pkg::prod_t         pc;
    lpi_pkg::prod_t         pd;
    lpi_pkg::prod_t         pe;
    lpi_pkg::prod_t         pf;
  } gb_t;

  // Fold the unused kind code onto ray
  function automatic lpi_pkg::kind_e kind_norm(logic [1:0] k);
    return k[1] ? lpi_pkg::KIND_RAY : lpi_pkg::kind_e'(k);
  endfunction

  logic  va_q, vb_q, vc_q;
  logic  en_a, en_b, en_c;
  ga_t   a_d, a_q;
  gb_t   b_d, b_q;
  lpi_pkg::geom_t c_d, c_q;

  lpi_pkg::kind_e  k1, k2;
  logic            swap;
  lpi_pkg::coord_t c [8];

  // Stage enables: a stage moves when empty or when its successor moves
  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;
  assign out_valid_o = vc_q;
  assign out_geom_o  = c_q;

  // Order the pair by kind and form the differences
  always_comb begin
    k1   = kind_norm(in_user_i[1:0]);
    k2   = kind_norm(in_user_i[3:2]);
    swap = k1 > k2;
    for (int j = 0; j < 8; j++) begin
      c[j] = lpi_pkg::coord_t'(in_data_i[j*lpi_pkg::COORD_WIDTH +: lpi_pkg::COORD_WIDTH]);
    end
    a_d.ka    = swap ? k2 : k1;
    a_d.kb    = swap ? k1 : k2;
    a_d.xs[0] = swap ? c[4] : c[0];
    a_d.ys[0] = swap ? c[5] : c[1];
    a_d.xs[1] = swap ? c[6] : c[2];
    a_d.ys[1] = swap ? c[7] : c[3];
    a_d.xs[2] = swap ? c[0] : c[4];
    a_d.ys[2] = swap ? c[1] : c[5];
    a_d.xs[3] = swap ? c[2] : c[6];
    a_d.ys[3] = swap ? c[3] : c[7];
    a_d.dx1 = lpi_pkg::diff_t'($signed(a_d.xs[1])) - lpi_pkg::diff_t'($signed(a_d.xs[0]));
    a_d.dy1 = lpi_pkg::diff_t'($signed(a_d.ys[1])) - lpi_pkg::diff_t'($signed(a_d.ys[0]));
    a_d.dx2 = lpi_pkg::diff_t'($signed(a_d.xs[3])) - lpi_pkg::diff_t'($signed(a_d.xs[2]));
    a_d.dy2 = lpi_pkg::diff_t'($signed(a_d.ys[3])) - lpi_pkg::diff_t'($signed(a_d.ys[2]));
    a_d.ex  = lpi_pkg::diff_t'($signed(a_d.xs[2])) - lpi_pkg::diff_t'($signed(a_d.xs[0]));
    a_d.ey  = lpi_pkg::diff_t'($signed(a_d.ys[2])) - lpi_pkg::diff_t'($signed(a_d.ys[0]));
  end

  // Cross product terms and degenerate flags
  always_comb begin
    b_d.ka    = a_q.ka;
    b_d.kb    = a_q.kb;
    b_d.xs    = a_q.xs;
    b_d.ys    = a_q.ys;
    b_d.dx1   = a_q.dx1;
    b_d.dy1   = a_q.dy1;
    b_d.degen = (a_q.dx1 == '0 && a_q.dy1 == '0) || (a_q.dx2 == '0 && a_q.dy2 == '0);
    b_d.use_x = a_q.dx1 != '0;
    b_d.pa = lpi_pkg::prod_t'($signed(a_q.dx1)) * lpi_pkg::prod_t'($signed(a_q.dy2));
    b_d.pb = lpi_pkg::prod_t'($signed(a_q.dy1)) * lpi_pkg::prod_t'($signed(a_q.dx2));
    b_d.pc = lpi_pkg::prod_t'($signed(a_q.ex))  * lpi_pkg::prod_t'($signed(a_q.dy2));
    b_d.pd = lpi_pkg::prod_t'($signed(a_q.ey))  * lpi_pkg::prod_t'($signed(a_q.dx2));
    b_d.pe = lpi_pkg::prod_t'($signed(a_q.ex))  * lpi_pkg::prod_t'($signed(a_q.dy1));
    b_d.pf = lpi_pkg::prod_t'($signed(a_q.ey))  * lpi_pkg::prod_t'($signed(a_q.dx1));
  end

  // Determinant and the two crossing numerators
  always_comb begin
    c_d.ka    = b_q.ka;
    c_d.kb    = b_q.kb;
    c_d.degen = b_q.degen;
    c_d.use_x = b_q.use_x;
    c_d.xs    = b_q.xs;
    c_d.ys    = b_q.ys;
    c_d.dx1   = b_q.dx1;
    c_d.dy1   = b_q.dy1;
    c_d.den = lpi_pkg::sum_t'($signed(b_q.pa)) - lpi_pkg::sum_t'($signed(b_q.pb));
    c_d.tn  = lpi_pkg::sum_t'($signed(b_q.pc)) - lpi_pkg::sum_t'($signed(b_q.pd));
    c_d.un  = lpi_pkg::sum_t'($signed(b_q.pe)) - lpi_pkg::sum_t'($signed(b_q.pf));
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= a_d;
    if (en_b) b_q <= b_d;
    if (en_c) c_q <= c_d;
  end

endmodule

[rtl/lpi_classify.sv]
module lpi_classify (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lpi_pkg::geom_t  in_geom_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpi_pkg::divin_t out_div_o
);

  typedef struct packed {
    lpi_pkg::status_e  status;
    lpi_pkg::coord_t   bx;
    lpi_pkg::coord_t   by;
    lpi_pkg::diff_t    sx;
    lpi_pkg::diff_t    sy;
    lpi_pkg::sum_t     num;
    lpi_pkg::sum_t     dvs;
  } cd_t;

  typedef struct packed {
    lpi_pkg::status_e              status;
    lpi_pkg::num_t [1:0]           mb;
    lpi_pkg::num_t [1:0]           ms;
    logic [lpi_pkg::SUM_W-1:0]     dvs;
  } ce_t;

  // Crossing parameter within the extent of a primitive
  function automatic logic in_span(lpi_pkg::kind_e kind, lpi_pkg::sum_t n, lpi_pkg::sum_t den);
    logic ok;
    unique case (kind)
      lpi_pkg::KIND_SEGMENT: ok = (n >= 0) && (n <= den);
      lpi_pkg::KIND_RAY:     ok = n >= 0;
      default:               ok = 1'b1;
    endcase
    return ok;
  endfunction

  logic vd_q, ve_q, vf_q;
  logic en_d, en_e, en_f;
  cd_t  d_d, d_q;
  ce_t  e_d, e_q;
  lpi_pkg::divin_t f_d, f_q;

  lpi_pkg::geom_t  g;
  lpi_pkg::sum_t   den_abs, tn_n, un_n;
  logic            den_neg;
  lpi_pkg::coord_t p [4];
  lpi_pkg::coord_t l0, h0, l1, h1, lo, hi;
  logic            lf0, hf0, lf1, hf1, have_lo, have_hi;
  logic [1:0]      sel;
  lpi_pkg::num_t   n_sum [2];

  assign en_f        = !vf_q || out_ready_i;
  assign en_e        = !ve_q || en_f;
  assign en_d        = !vd_q || en_e;
  assign in_ready_o  = en_d;
  assign out_valid_o = vf_q;
  assign out_div_o   = f_q;
  assign g           = in_geom_i;

  // Classify the pair and pick the operands of the crossing point
  always_comb begin
    den_neg = g.den[lpi_pkg::SUM_W-1];
    den_abs = den_neg ? -g.den : g.den;
    tn_n    = den_neg ? -g.tn  : g.tn;
    un_n    = den_neg ? -g.un  : g.un;

    // Collinear case: intervals along one axis
    for (int i = 0; i < 4; i++) begin
      p[i] = g.use_x ? g.xs[i] : g.ys[i];
    end
    l0 = (p[0] < p[1]) ? p[0] : p[1];
    h0 = (p[0] < p[1]) ? p[1] : p[0];
    lf0 = 1'b1;
    hf0 = 1'b1;
    if (g.ka == lpi_pkg::KIND_RAY) begin
      l0  = p[0];
      h0  = p[0];
      hf0 = !(p[1] > p[0]);
      lf0 = p[1] > p[0];
    end
    l1 = (p[2] < p[3]) ? p[2] : p[3];
    h1 = (p[2] < p[3]) ? p[3] : p[2];
    lf1 = 1'b1;
    hf1 = 1'b1;
    if (g.kb == lpi_pkg::KIND_RAY) begin
      l1  = p[2];
      h1  = p[2];
      hf1 = !(p[3] > p[2]);
      lf1 = p[3] > p[2];
    end
    have_lo = lf0 || lf1;
    have_hi = hf0 || hf1;
    lo = (lf1 && (!lf0 || l1 > l0)) ? l1 : l0;
    hi = (hf1 && (!hf0 || h1 < h0)) ? h1 : h0;
    priority if (p[0] == lo) sel = 2'd0;
    else if (p[1] == lo)     sel = 2'd1;
    else if (p[2] == lo)     sel = 2'd2;
    else if (p[3] == lo)     sel = 2'd3;
    else                     sel = 2'd0;

    d_d.status = lpi_pkg::ST_NONE;
    d_d.bx     = '0;
    d_d.by     = '0;
    d_d.sx     = '0;
    d_d.sy     = '0;
    d_d.num    = '0;
    d_d.dvs    = lpi_pkg::sum_t'(1);
    priority if (g.degen) begin
      d_d.status = lpi_pkg::ST_NONE;
    end else if (g.den != '0) begin
      if (in_span(g.ka, tn_n, den_abs) && in_span(g.kb, un_n, den_abs)) begin
        d_d.status = lpi_pkg::ST_ONE;
        d_d.bx     = g.xs[0];
        d_d.by     = g.ys[0];
        d_d.sx     = g.dx1;
        d_d.sy     = g.dy1;
        d_d.num    = tn_n;
        d_d.dvs    = den_abs;
      end
    end else if (g.un != '0) begin
      d_d.status = lpi_pkg::ST_NONE;
    end else if (g.ka == lpi_pkg::KIND_LINE) begin
      d_d.status = lpi_pkg::ST_MANY;
    end else if (have_lo && have_hi && lo > hi) begin
      d_d.status = lpi_pkg::ST_NONE;
    end else if (have_lo && have_hi && lo == hi) begin
      d_d.status = lpi_pkg::ST_ONE;
      d_d.bx     = g.xs[sel];
      d_d.by     = g.ys[sel];
    end else begin
      d_d.status = lpi_pkg::ST_MANY;
    end
  end

  // Products of base with divisor and step with numerator
  always_comb begin
    e_d.status = d_q.status;
    e_d.dvs    = d_q.dvs;
    e_d.mb[0] = lpi_pkg::num_t'($signed(d_q.bx)) * lpi_pkg::num_t'($signed(d_q.dvs));
    e_d.mb[1] = lpi_pkg::num_t'($signed(d_q.by)) * lpi_pkg::num_t'($signed(d_q.dvs));
    e_d.ms[0] = lpi_pkg::num_t'($signed(d_q.sx)) * lpi_pkg::num_t'($signed(d_q.num));
    e_d.ms[1] = lpi_pkg::num_t'($signed(d_q.sy)) * lpi_pkg::num_t'($signed(d_q.num));
  end

  // Sum, split off the sign and scale by the fraction bits
  always_comb begin
    f_d.status = e_q.status;
    f_d.dvs    = e_q.dvs;
    for (int k = 0; k < 2; k++) begin
      n_sum[k]    = $signed(e_q.mb[k]) + $signed(e_q.ms[k]);
      f_d.neg[k]  = n_sum[k][lpi_pkg::NUM_W-1];
      f_d.mag[k]  = lpi_pkg::SHIFT_W'(f_d.neg[k] ? -n_sum[k] : n_sum[k]) << lpi_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= in_valid_i;
      if (en_e) ve_q <= vd_q;
      if (en_f) vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) d_q <= d_d;
    if (en_e) e_q <= e_d;
    if (en_f) f_q <= f_d;
  end

endmodule

[rtl/lpi_div.sv]
module lpi_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lpi_pkg::divin_t                in_div_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lpi_pkg::status_e               out_status_o,
  output logic [lpi_pkg::OUT_W-1:0]      out_px_o,
  output logic [lpi_pkg::OUT_W-1:0]      out_py_o,
  output logic                           out_sat_o
);

  localparam int NS = lpi_pkg::DIV_STAGES;

  typedef struct packed {
    lpi_pkg::status_e                    status;
    logic [1:0]                          neg;
    logic [1:0][lpi_pkg::SUM_W-1:0]      rem;
    logic [1:0][lpi_pkg::QUOT_W-1:0]     quo;
    logic [lpi_pkg::SUM_W-1:0]           dvs;
  } dstep_t;

  // Resolve a few quotient bits of both lanes, restoring form
  function automatic dstep_t div_steps(dstep_t s);
    logic [lpi_pkg::SUM_W:0] trial;
    dstep_t r;
    r = s;
    for (int k = 0; k < 2; k++) begin
      for (int b = 0; b < lpi_pkg::DIV_BPS; b++) begin
        trial = {r.rem[k], r.quo[k][lpi_pkg::QUOT_W-1]};
        r.quo[k] = {r.quo[k][lpi_pkg::QUOT_W-2:0], 1'b0};
        if (trial >= {1'b0, r.dvs}) begin
          trial = trial - {1'b0, r.dvs};
          r.quo[k][0] = 1'b1;
        end
        r.rem[k] = trial[lpi_pkg::SUM_W-1:0];
      end
    end
    return r;
  endfunction

  dstep_t st_q [NS];
  dstep_t st_in [NS];
  logic   v_q [NS];
  logic   en [NS+1];
  logic   vo_q;

  lpi_pkg::status_e           status_d;
  logic [lpi_pkg::OUT_W-1:0]  val_d [2];
  logic [1:0]                 sat_d;
  logic                       rnd;
  logic [lpi_pkg::RND_W-1:0]  q1;
  logic [lpi_pkg::CMP_W-1:0]  qw, lim;

  // Enable chain from the output register back to the first stage
  always_comb begin
    en[NS] = !vo_q || out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = vo_q;

  // Stage inputs: the first takes the dividend, the rest chain on
  always_comb begin
    st_in[0].status = in_div_i.status;
    st_in[0].neg    = in_div_i.neg;
    st_in[0].dvs    = in_div_i.dvs;
    for (int k = 0; k < 2; k++) begin
      st_in[0].rem[k] = '0;
      st_in[0].quo[k] = lpi_pkg::QUOT_W'(in_div_i.mag[k]);
    end
    for (int s = 1; s < NS; s++) begin
      st_in[s] = st_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (en[s]) st_q[s] <= div_steps(st_in[s]);
    end
  end

  // Round to nearest, restore the sign and clamp; zero unless a single point
  always_comb begin
    status_d = st_q[NS-1].status;
    rnd = 1'b0;
    q1  = '0;
    qw  = '0;
    lim = '0;
    for (int k = 0; k < 2; k++) begin
      rnd = {st_q[NS-1].rem[k], 1'b0} >= {1'b0, st_q[NS-1].dvs};
      q1  = lpi_pkg::RND_W'(st_q[NS-1].quo[k]) + lpi_pkg::RND_W'(rnd);
      qw  = lpi_pkg::CMP_W'(q1);
      lim = lpi_pkg::CMP_W'(st_q[NS-1].neg[k] ? lpi_pkg::SAT_NEG : lpi_pkg::SAT_POS);
      sat_d[k] = qw > lim;
      if (sat_d[k]) begin
        val_d[k] = lim[lpi_pkg::OUT_W-1:0];
      end else begin
        val_d[k] = st_q[NS-1].neg[k] ? -qw[lpi_pkg::OUT_W-1:0] : qw[lpi_pkg::OUT_W-1:0];
      end
      if (status_d != lpi_pkg::ST_ONE) begin
        val_d[k] = '0;
        sat_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en[NS]) begin
      vo_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS]) begin
      out_status_o <= status_d;
      out_px_o     <= val_d[0];
      out_py_o     <= val_d[1];
      out_sat_o    <= |sat_d;
    end
  end

endmodule

[rtl/linear_primitive_intersect.sv]
// Intersection of two linear primitives (line, segment or ray, each given by
// two integer points) with a stream interface on both sides. The pair is
// ordered by kind, classified with exact integer cross products as having no,
// one or infinitely many common points, and a single common point is returned
// in signed fixed point with lpi_pkg::FRAC_BITS fraction bits, rounded to
// nearest with ties away from zero and clamped with a flag when it does not
// fit in 64 bits. One item is accepted per cycle while no stall backs up the
// pipeline; the quotient comes from a restoring divider that resolves three
// quotient bits per stage. Every stage holds its own valid bit, so an item is
// still taken while a result waits on the output as long as a bubble remains
// in the pipeline.
module linear_primitive_intersect (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_x1, first_y1, first_x2, first_y2, second_x1, second_y1, second_x2, second_y2
  input  logic [lpi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // first_kind, second_kind
  input  logic [lpi_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // point_x, point_y
  output logic [lpi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status, saturated
  output logic [lpi_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  logic            geom_valid, geom_ready;
  lpi_pkg::geom_t  geom;
  logic            cls_valid, cls_ready;
  lpi_pkg::divin_t div_in;
  lpi_pkg::status_e           status;
  logic [lpi_pkg::OUT_W-1:0]  px, py;
  logic                       sat;

  lpi_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (geom_valid),
    .out_ready_i (geom_ready),
    .out_geom_o  (geom)
  );

  lpi_classify u_cls (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geom_valid),
    .in_ready_o  (geom_ready),
    .in_geom_i   (geom),
    .out_valid_o (cls_valid),
    .out_ready_i (cls_ready),
    .out_div_o   (div_in)
  );

  lpi_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cls_valid),
    .in_ready_o   (cls_ready),
    .in_div_i     (div_in),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_px_o     (px),
    .out_py_o     (py),
    .out_sat_o    (sat)
  );

  assign m_axis_tdata = {py, px};
  assign m_axis_tuser = {sat, status};

endmodule

[rtl/lpi_checker.sv]
module lpi_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [lpi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic [lpi_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  logic                       one;
  logic                       sat;
  logic [lpi_pkg::OUT_W-1:0]  px, py;

  assign one = m_axis_tuser[1:0] == lpi_pkg::ST_ONE;
  assign sat = m_axis_tuser[2];
  assign px  = m_axis_tdata[lpi_pkg::OUT_W-1:0];
  assign py  = m_axis_tdata[lpi_pkg::OUT_DATA_W-1:lpi_pkg::OUT_W];

  // No single point: coordinates and flag are zero
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !one |-> px == '0 && py == '0 && !sat)
    else $error("point data without a single common point");

  // Clamping only happens on a single point
  a_sat_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat |-> one)
    else $error("saturation flag without a single common point");

  // A clamped item carries a limit value in one coordinate
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sat |->
      px == lpi_pkg::SAT_POS || px == lpi_pkg::SAT_NEG ||
      py == lpi_pkg::SAT_POS || py == lpi_pkg::SAT_NEG)
    else $error("saturation flag without a clamped coordinate");

  // Hold a stalled item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output item changed");

endmodule

bind linear_primitive_intersect lpi_checker u_lpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_linear_primitive_intersect.sv]
module tb_linear_primitive_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CycleLimit  = 1000000;
  localparam int  DrainCycles = 80;

  typedef struct {
    logic [1:0]      kind;
    lpi_pkg::coord_t x1, y1, x2, y2;
  } prim_t;

  typedef struct {
    prim_t a, b;
  } pair_t;

  typedef struct {
    lpi_pkg::status_e          status;
    logic [lpi_pkg::OUT_W-1:0] px, py;
    logic                      sat;
  } crossing_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [lpi_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic [lpi_pkg::IN_USER_W-1:0]    s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [lpi_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic [lpi_pkg::OUT_USER_W-1:0]   m_axis_tuser;

  crossing_t pending_crossings[$];
  bit        send_idle = 1'b1;
  bit        recv_stall = 1'b1;
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_results = 0;
  int        n_status[3] = '{0, 0, 0};
  int        n_sat = 0;
  int        n_cycles = 0;

  linear_primitive_intersect dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               pending_crossings.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Fixed-point value of base + step * num / den, rounded half away from zero
  function automatic logic [lpi_pkg::OUT_W-1:0] fixed_coord(longint base, longint step,
                                                            longint num, longint den,
                                                            inout logic sat);
    logic signed [127:0]       sb, ss, sn, sd, acc;
    logic [127:0]              m, q, r, d;
    logic                      neg;
    logic [lpi_pkg::OUT_W-1:0] lim;
    sb = 128'(base); ss = 128'(step); sn = 128'(num); sd = 128'(den);
    acc = sb * sd + ss * sn;
    neg = acc < 0;
    m = neg ? -acc : acc;
    m = m << lpi_pkg::FRAC_BITS;
    d = sd;
    q = m / d;
    r = m % d;
    if (r >= d - r) q = q + 128'd1;
    lim = neg ? lpi_pkg::SAT_NEG : lpi_pkg::SAT_POS;
    if (q > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return neg ? -q[lpi_pkg::OUT_W-1:0] : q[lpi_pkg::OUT_W-1:0];
  endfunction

  // Crossing of two primitives, exact integer decisions
  function automatic crossing_t predict_crossing(pair_t p);
    crossing_t  c;
    prim_t      pa, pb;
    logic [1:0] ka, kb;
    longint     x[4], y[4], s[4];
    longint     dx1, dy1, dx2, dy2, ex, ey, den, tn, un, lo, hi, l, h, st, en;
    bit         have_lo, have_hi, lfin, hfin;
    int         sel;
    logic [1:0] kk[2];
    c.status = lpi_pkg::ST_NONE; c.px = '0; c.py = '0; c.sat = 1'b0;
    pa = p.a; pb = p.b;
    ka = pa.kind[1] ? lpi_pkg::KIND_RAY : pa.kind;
    kb = pb.kind[1] ? lpi_pkg::KIND_RAY : pb.kind;
    if (ka > kb) begin
      pa = p.b; pb = p.a;
      {ka, kb} = {kb, ka};
    end
    x[0] = longint'(pa.x1); y[0] = longint'(pa.y1);
    x[1] = longint'(pa.x2); y[1] = longint'(pa.y2);
    x[2] = longint'(pb.x1); y[2] = longint'(pb.y1);
    x[3] = longint'(pb.x2); y[3] = longint'(pb.y2);
    dx1 = x[1] - x[0]; dy1 = y[1] - y[0];
    dx2 = x[3] - x[2]; dy2 = y[3] - y[2];
    ex = x[2] - x[0]; ey = y[2] - y[0];
    den = dx1 * dy2 - dy1 * dx2;
    if ((dx1 == 0 && dy1 == 0) || (dx2 == 0 && dy2 == 0)) begin
      c.status = lpi_pkg::ST_NONE;
    end else if (den != 0) begin
      tn = ex * dy2 - ey * dx2;
      un = ex * dy1 - ey * dx1;
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if ((ka != lpi_pkg::KIND_SEGMENT || (tn >= 0 && tn <= den)) &&
          (ka != lpi_pkg::KIND_RAY || tn >= 0) &&
          (kb != lpi_pkg::KIND_SEGMENT || (un >= 0 && un <= den)) &&
          (kb != lpi_pkg::KIND_RAY || un >= 0)) begin
        c.status = lpi_pkg::ST_ONE;
        c.px = fixed_coord(x[0], dx1, tn, den, c.sat);
        c.py = fixed_coord(y[0], dy1, tn, den, c.sat);
      end
    end else if (dx1 * ey - dy1 * ex != 0) begin
      c.status = lpi_pkg::ST_NONE;
    end else if (ka == lpi_pkg::KIND_LINE) begin
      c.status = lpi_pkg::ST_MANY;
    end else begin
      // Collinear: intersect the intervals along one axis
      have_lo = 1'b0; have_hi = 1'b0; lo = 0; hi = 0;
      kk[0] = ka; kk[1] = kb;
      for (int i = 0; i < 4; i++) s[i] = (dx1 != 0) ? x[i] : y[i];
      for (int i = 0; i < 2; i++) begin
        st = s[2*i]; en = s[2*i+1];
        lfin = 1'b1; hfin = 1'b1;
        l = (st < en) ? st : en;
        h = (st < en) ? en : st;
        if (kk[i] == lpi_pkg::KIND_RAY) begin
          if (en > st) hfin = 1'b0;
          else lfin = 1'b0;
          l = st; h = st;
        end
        if (lfin && (!have_lo || l > lo)) begin
          lo = l; have_lo = 1'b1;
        end
        if (hfin && (!have_hi || h < hi)) begin
          hi = h; have_hi = 1'b1;
        end
      end
      if (have_lo && have_hi && lo > hi) begin
        c.status = lpi_pkg::ST_NONE;
      end else if (have_lo && have_hi && lo == hi) begin
        sel = 0;
        for (int i = 3; i >= 0; i--) if (s[i] == lo) sel = i;
        c.status = lpi_pkg::ST_ONE;
        c.px = fixed_coord(x[sel], 0, 0, 1, c.sat);
        c.py = fixed_coord(y[sel], 0, 0, 1, c.sat);
      end else begin
        c.status = lpi_pkg::ST_MANY;
      end
    end
    return c;
  endfunction

  function automatic pair_t mk_pair(logic [1:0] ka, int ax1, int ay1, int ax2, int ay2,
                                    logic [1:0] kb, int bx1, int by1, int bx2, int by2);
    pair_t p;
    p.a.kind = ka;
    p.a.x1 = lpi_pkg::coord_t'(ax1); p.a.y1 = lpi_pkg::coord_t'(ay1);
    p.a.x2 = lpi_pkg::coord_t'(ax2); p.a.y2 = lpi_pkg::coord_t'(ay2);
    p.b.kind = kb;
    p.b.x1 = lpi_pkg::coord_t'(bx1); p.b.y1 = lpi_pkg::coord_t'(by1);
    p.b.x2 = lpi_pkg::coord_t'(bx2); p.b.y2 = lpi_pkg::coord_t'(by2);
    return p;
  endfunction

  // Drive one pair, hold until taken, log its expected crossing
  task automatic send_pair(pair_t p);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.b.y2, p.b.x2, p.b.y1, p.b.x1, p.a.y2, p.a.x2, p.a.y1, p.a.x1};
    s_axis_tuser  <= {p.b.kind, p.a.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_crossings.push_back(predict_crossing(p));
    n_sent++;
  endtask

  task automatic lower_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  // Small signed offset in -half .. +half
  function automatic int soff(int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Random pair drawn from one of several geometric families
  function automatic pair_t rand_pair();
    pair_t p;
    int    bx, by, dx, dy, ddx, ddy;
    p.a.kind = 2'($urandom_range(0, 2));
    p.b.kind = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // full-range coordinates
        p.a.x1 = lpi_pkg::coord_t'($urandom); p.a.y1 = lpi_pkg::coord_t'($urandom);
        p.a.x2 = lpi_pkg::coord_t'($urandom); p.a.y2 = lpi_pkg::coord_t'($urandom);
        p.b.x1 = lpi_pkg::coord_t'($urandom); p.b.y1 = lpi_pkg::coord_t'($urandom);
        p.b.x2 = lpi_pkg::coord_t'($urandom); p.b.y2 = lpi_pkg::coord_t'($urandom);
      end
      3, 4: begin
        // small coordinates: frequent parallel and degenerate cases
        p.a.x1 = lpi_pkg::coord_t'(soff(3)); p.a.y1 = lpi_pkg::coord_t'(soff(3));
        p.a.x2 = lpi_pkg::coord_t'(soff(3)); p.a.y2 = lpi_pkg::coord_t'(soff(3));
        p.b.x1 = lpi_pkg::coord_t'(soff(3)); p.b.y1 = lpi_pkg::coord_t'(soff(3));
        p.b.x2 = lpi_pkg::coord_t'(soff(3)); p.b.y2 = lpi_pkg::coord_t'(soff(3));
      end
      5, 6, 7: begin
        // points along one line direction, all four collinear in half the draws
        bx = soff(200000); by = soff(200000);
        dx = soff(4); dy = soff(4);
        if ($urandom_range(0, 3) == 0) dx = 0;
        p.a.x1 = lpi_pkg::coord_t'(bx + dx * soff(10));
        p.a.y1 = lpi_pkg::coord_t'(by + dy * soff(10));
        p.a.x2 = lpi_pkg::coord_t'(bx + dx * soff(10));
        p.a.y2 = lpi_pkg::coord_t'(by + dy * soff(10));
        p.b.x1 = lpi_pkg::coord_t'(bx + dx * soff(10));
        p.b.y1 = lpi_pkg::coord_t'(by + dy * soff(10));
        p.b.x2 = lpi_pkg::coord_t'(bx + dx * soff(10));
        p.b.y2 = lpi_pkg::coord_t'(by + dy * soff(10));
        // keep the x and y steps in proportion so the points stay collinear
        if ($urandom_range(0, 1) == 0) begin
          int t1, t2, t3, t4;
          t1 = soff(10); t2 = soff(10);
          t3 = soff(10); t4 = soff(10);
          p.a.x1 = lpi_pkg::coord_t'(bx + dx * t1); p.a.y1 = lpi_pkg::coord_t'(by + dy * t1);
          p.a.x2 = lpi_pkg::coord_t'(bx + dx * t2); p.a.y2 = lpi_pkg::coord_t'(by + dy * t2);
          p.b.x1 = lpi_pkg::coord_t'(bx + dx * t3); p.b.y1 = lpi_pkg::coord_t'(by + dy * t3);
          p.b.x2 = lpi_pkg::coord_t'(bx + dx * t4); p.b.y2 = lpi_pkg::coord_t'(by + dy * t4);
        end
      end
      default: begin
        // nearly parallel long primitives: far crossings and clamping
        dx = int'($urandom_range(0, 262143)) + 100000;
        dy = int'($urandom_range(0, 262143)) + 100000;
        if ($urandom_range(0, 1) == 0) dx = -dx;
        ddx = soff(1); ddy = soff(1);
        bx = soff(100000); by = soff(100000);
        p.a.x1 = lpi_pkg::coord_t'(bx); p.a.y1 = lpi_pkg::coord_t'(by);
        p.a.x2 = lpi_pkg::coord_t'(bx + dx); p.a.y2 = lpi_pkg::coord_t'(by + dy);
        bx = soff(100000); by = soff(100000);
        p.b.x1 = lpi_pkg::coord_t'(bx); p.b.y1 = lpi_pkg::coord_t'(by);
        p.b.x2 = lpi_pkg::coord_t'(bx + dx + ddx); p.b.y2 = lpi_pkg::coord_t'(by + dy + ddy);
      end
    endcase
    return p;
  endfunction

  // Take results, with random stall bursts while recv_stall is set
  initial begin
    wait (rst_ni);
    forever begin
      if (recv_stall && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Compare each result with the oldest expected crossing
  always @(posedge clk_i) begin
    crossing_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_crossings.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%h", $time, m_axis_tdata,
                 m_axis_tuser);
        n_errors++;
      end else begin
        e = pending_crossings.pop_front();
        n_status[e.status]++;
        if (e.sat) n_sat++;
        if (m_axis_tuser[1:0] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   m_axis_tuser[1:0]);
          n_errors++;
        end
        if (m_axis_tdata[lpi_pkg::OUT_W-1:0] !== e.px) begin
          $display("%0t: point_x expected %h actual %h", $time, e.px,
                   m_axis_tdata[lpi_pkg::OUT_W-1:0]);
          n_errors++;
        end
        if (m_axis_tdata[2*lpi_pkg::OUT_W-1:lpi_pkg::OUT_W] !== e.py) begin
          $display("%0t: point_y expected %h actual %h", $time, e.py,
                   m_axis_tdata[2*lpi_pkg::OUT_W-1:lpi_pkg::OUT_W]);
          n_errors++;
        end
        if (m_axis_tuser[2] !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, m_axis_tuser[2]);
          n_errors++;
        end
      end
    end
  end

  task automatic wait_all_results();
    while (pending_crossings.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, every kind pairing and each special case
  task automatic run_directed_pairs();
    send_pair(mk_pair(lpi_pkg::KIND_LINE, -524288, -524288, 524287, 524287,
                      lpi_pkg::KIND_LINE, -524288, 524287, 524287, -524288));
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 10, 10,
                      lpi_pkg::KIND_SEGMENT, 0, 10, 10, 0));
    send_pair(mk_pair(lpi_pkg::KIND_RAY, 0, 0, 1, 1, lpi_pkg::KIND_SEGMENT, 0, 10, 10, 0));
    send_pair(mk_pair(lpi_pkg::KIND_RAY, 0, 0, -1, -1, lpi_pkg::KIND_LINE, 0, 10, 10, 0));
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 2, 0, lpi_pkg::KIND_RAY, 5, -1, 5, 1));
    send_pair(mk_pair(lpi_pkg::KIND_LINE, 0, 0, 3, 1, lpi_pkg::KIND_LINE, 0, 0, 1, 3));
    // degenerate primitive
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 4, 4, 4, 4, lpi_pkg::KIND_LINE, 0, 0, 9, 9));
    // parallel, apart
    send_pair(mk_pair(lpi_pkg::KIND_LINE, 0, 0, 1, 1, lpi_pkg::KIND_LINE, 0, 1, 1, 2));
    // coincident with a line
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 1, 1, lpi_pkg::KIND_LINE, 5, 5, 7, 7));
    // coincident vertical lines
    send_pair(mk_pair(lpi_pkg::KIND_LINE, 3, 0, 3, 1, lpi_pkg::KIND_LINE, 3, 9, 3, -4));
    // collinear segments touching at one end, and overlapping, and apart
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 2, 2, lpi_pkg::KIND_SEGMENT, 2, 2, 5, 5));
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 3, 3, lpi_pkg::KIND_SEGMENT, 2, 2, 5, 5));
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 1, 1, lpi_pkg::KIND_SEGMENT, 2, 2, 5, 5));
    // collinear vertical segments touching
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 7, -3, 7, 0, lpi_pkg::KIND_SEGMENT, 7, 4, 7, 0));
    // opposite rays meeting at their starts
    send_pair(mk_pair(lpi_pkg::KIND_RAY, 1, 1, 2, 2, lpi_pkg::KIND_RAY, 1, 1, 0, 0));
    // rays in the same direction
    send_pair(mk_pair(lpi_pkg::KIND_RAY, 1, 1, 2, 2, lpi_pkg::KIND_RAY, 4, 4, 9, 9));
    // ray touching a segment end
    send_pair(mk_pair(lpi_pkg::KIND_RAY, 0, 5, 0, 9, lpi_pkg::KIND_SEGMENT, 0, 1, 0, 5));
    // kinds given in swapped order
    send_pair(mk_pair(lpi_pkg::KIND_RAY, -524288, 0, 524287, 0,
                      lpi_pkg::KIND_LINE, 1, -524288, 1, 524287));
    // parallel lines across the full coordinate range, offset by one
    send_pair(mk_pair(lpi_pkg::KIND_LINE, -524288, -524288, 524287, 524286,
                      lpi_pkg::KIND_LINE, -524288, -524287, 524287, 524287));
    send_pair(mk_pair(lpi_pkg::KIND_LINE, 524287, -524288, -524288, 524286,
                      lpi_pkg::KIND_LINE, 524287, -524287, -524288, 524287));
    // rounding of thirds
    send_pair(mk_pair(lpi_pkg::KIND_SEGMENT, 0, 0, 1, 0, lpi_pkg::KIND_SEGMENT, 0, -1, 1, 2));
    send_pair(mk_pair(lpi_pkg::KIND_LINE, 0, 0, 2, 0, lpi_pkg::KIND_LINE, -1, -1, 0, 2));
  endtask

  task automatic run_random_pairs(int count);
    repeat (count) send_pair(rand_pair());
  endtask

  // Hold the sender until the pipeline has emptied
  task automatic run_backlog_pause();
    lower_valid();
    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_full_rate(int count);
    send_idle = 1'b0;
    recv_stall = 1'b0;
    repeat (count) send_pair(rand_pair());
    lower_valid();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed_pairs();
    run_random_pairs(900);
    run_backlog_pause();
    run_random_pairs(700);
    run_full_rate(200);
    wait_all_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d pairs, checked %0d results: none %0d, one %0d, many %0d",
             n_sent, n_results, n_status[0], n_status[1], n_status[2]);
    $display("clamped crossings %0d, mismatches %0d", n_sat, n_errors);
    if (n_errors == 0 && pending_crossings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
